// ===== design/bbc_pkg.sv =====
// Shared types and constants for the block buffer cache tag table.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps
package bbc_pkg;
	localparam int NUM_ENTRIES = 16;
	localparam int LBA_BITS    = 48;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = 5;
	localparam int REFS_W      = 16;
	localparam int STAMP_W     = 32;
	localparam int RANGE_W     = 16;
	localparam int FLAG_W      = 4;

	// flag bits
	localparam int FLAG_DIRTY    = 0;
	localparam int FLAG_UPTODATE = 1;
	localparam int FLAG_FLUSH    = 2;
	localparam int FLAG_TMP      = 3;

	// function codes on the request channel
	localparam logic [2:0] FN_ACQUIRE = 3'd0;
	localparam logic [2:0] FN_RELEASE = 3'd1;
	localparam logic [2:0] FN_INVAL   = 3'd2;
	localparam logic [2:0] FN_DROP    = 3'd3;
	localparam logic [2:0] FN_WFLAGS  = 3'd4;
	localparam logic [2:0] FN_OLDEST  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FREE  = 2'd1;
	localparam logic [1:0] ST_NOT_HELD = 2'd2;

	// config register indexes
	localparam logic CFG_CAPACITY   = 1'b0;
	localparam logic CFG_WRITE_BACK = 1'b1;

	typedef enum logic [2:0] {
		OP_ACQUIRE, OP_RELEASE, OP_INVAL, OP_DROP, OP_WFLAGS, OP_OLDEST, OP_NOP
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [LBA_BITS-1:0]  lba;
		logic [RANGE_W-1:0]   range_count;
		logic [FLAG_W-1:0]    flag_bits;
	} item_t;

	typedef struct packed {
		logic                 valid;
		logic [LBA_BITS-1:0]  lba;
		logic [REFS_W-1:0]    refs;
		logic [STAMP_W-1:0]   stamp;
		logic [FLAG_W-1:0]    flags;
		logic                 ready;
	} entry_t;
endpackage

// ===== design/bbc_if.sv =====
// Request and response channel interfaces of the block buffer cache.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
interface bbc_req_if;
	import bbc_pkg::*;
	logic                valid;
	logic                ready;
	logic [2:0]          func;
	logic [LBA_BITS-1:0] lba;
	logic [RANGE_W-1:0]  range_count;
	logic [FLAG_W-1:0]   flag_bits;
	modport source (output valid, func, lba, range_count, flag_bits, input ready);
	modport sink (input valid, func, lba, range_count, flag_bits, output ready);
endinterface

interface bbc_rsp_if;
	import bbc_pkg::*;
	logic                valid;
	logic                ready;
	logic                found;
	logic                is_new;
	logic [1:0]          status;
	logic [IDX_W-1:0]    entry_index;
	logic [LBA_BITS-1:0] out_lba;
	logic [FLAG_W-1:0]   out_flags;
	logic                flush_request;
	logic                freed;
	logic                cache_full;
	logic [CNT_W-1:0]    blocks_held;
	logic [CNT_W-1:0]    peak_blocks;
	logic [REFS_W-1:0]   ref_count_out;
	modport source (output valid, found, is_new, status, entry_index, out_lba, out_flags,
		flush_request, freed, cache_full, blocks_held, peak_blocks, ref_count_out,
		input ready);
	modport sink (input valid, found, is_new, status, entry_index, out_lba, out_flags,
		flush_request, freed, cache_full, blocks_held, peak_blocks, ref_count_out,
		output ready);
endinterface

// ===== design/bbc_front.sv =====
// Front end: accepts requests, decodes the function code, queues items.
// Depends on bbc_pkg and bbc_req_if.
`timescale 1ns / 1ps
module bbc_front (
	input  logic           clk,
	input  logic           arst_n,
	bbc_req_if.sink        req,
	output logic           item_valid,
	input  logic           item_ready,
	output bbc_pkg::item_t item
);
	import bbc_pkg::*;

	localparam int QDEPTH = 2;

	item_t      fifo_q [QDEPTH];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	item_t      dec;
	logic       push;
	logic       pop;

	// decode the function code
	always_comb begin
		dec.lba         = req.lba;
		dec.range_count = req.range_count;
		dec.flag_bits   = req.flag_bits;
		unique case (req.func)
			FN_ACQUIRE: dec.op = OP_ACQUIRE;
			FN_RELEASE: dec.op = OP_RELEASE;
			FN_INVAL:   dec.op = OP_INVAL;
			FN_DROP:    dec.op = OP_DROP;
			FN_WFLAGS:  dec.op = OP_WFLAGS;
			FN_OLDEST:  dec.op = OP_OLDEST;
			default:    dec.op = OP_NOP;
		endcase
	end

	assign req.ready  = (count_q != 2'(QDEPTH));
	assign push       = req.valid && req.ready;
	assign item_valid = (count_q != 2'd0);
	assign pop        = item_valid && item_ready;
	assign item       = fifo_q[rptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== design/bbc_engine.sv =====
// Back end: scans the tag table one entry per cycle, then applies the operation.
// Depends on bbc_pkg and bbc_rsp_if.
`timescale 1ns / 1ps
module bbc_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  bbc_pkg::item_t        item,
	input  logic [bbc_pkg::CNT_W-1:0] capacity,
	input  logic                  write_back,
	bbc_rsp_if.source             rsp
);
	import bbc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ACT} state_t;

	typedef struct packed {
		logic                found;
		logic                is_new;
		logic [1:0]          status;
		logic [IDX_W-1:0]    entry_index;
		logic [LBA_BITS-1:0] out_lba;
		logic [FLAG_W-1:0]   out_flags;
		logic                flush_request;
		logic                freed;
		logic                cache_full;
		logic [CNT_W-1:0]    blocks_held;
		logic [CNT_W-1:0]    peak_blocks;
		logic [REFS_W-1:0]   ref_count_out;
	} res_t;

	state_t              state_q;
	item_t               item_q;
	logic [IDX_W-1:0]    idx_q;
	logic                hit_q, free_ok_q, old_ok_q, any_q;
	logic [IDX_W-1:0]    hit_idx_q, free_idx_q, old_idx_q;
	logic [STAMP_W-1:0]  old_stamp_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [CNT_W-1:0]    held_q, peak_q;
	logic                rsp_valid_q;
	res_t                rsp_q;

	// table storage
	logic                valid_q [NUM_ENTRIES];
	logic                ready_q [NUM_ENTRIES];
	logic [LBA_BITS-1:0] lba_q   [NUM_ENTRIES];
	logic [REFS_W-1:0]   refs_q  [NUM_ENTRIES];
	logic [STAMP_W-1:0]  stampe_q[NUM_ENTRIES];
	logic [FLAG_W-1:0]   flags_q [NUM_ENTRIES];

	logic [IDX_W-1:0]    act_idx, ridx;
	entry_t              cur, rec;
	logic                we;
	logic [IDX_W-1:0]    widx;
	logic                out_free;
	logic [LBA_BITS-1:0] diff;
	logic                match, in_range;
	res_t                res;
	logic [STAMP_W-1:0]  stamp_n;
	logic [CNT_W-1:0]    held_n, peak_n;

	assign act_idx = (item_q.op == OP_ACQUIRE && !hit_q) ? free_idx_q :
		(item_q.op == OP_OLDEST) ? old_idx_q : hit_idx_q;
	assign ridx = (state_q == S_SCAN) ? idx_q : act_idx;

	// single read port
	always_comb begin
		cur.valid = valid_q[ridx];
		cur.ready = ready_q[ridx];
		cur.lba   = lba_q[ridx];
		cur.refs  = refs_q[ridx];
		cur.stamp = stampe_q[ridx];
		cur.flags = flags_q[ridx];
	end

	assign match    = cur.valid && (cur.lba == item_q.lba);
	assign diff     = cur.lba - item_q.lba;
	assign in_range = cur.valid && (cur.lba >= item_q.lba) &&
		(diff < LBA_BITS'(item_q.range_count));
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign item_ready = (state_q == S_IDLE);

	// entry update and result for the scan and action steps
	always_comb begin
		rec     = cur;
		we      = 1'b0;
		widx    = ridx;
		res     = '0;
		stamp_n = stamp_q;
		held_n  = held_q;
		peak_n  = peak_q;
		if (state_q == S_SCAN) begin
			if (item_q.op == OP_INVAL && in_range) begin
				we = 1'b1;
				rec.flags[FLAG_DIRTY]    = 1'b0;
				rec.flags[FLAG_UPTODATE] = 1'b0;
				rec.ready = 1'b0;
			end
		end else if (state_q == S_ACT) begin
			case (item_q.op)
				OP_ACQUIRE: begin
					if (hit_q) begin
						we = 1'b1;
						if (cur.refs == '0) begin
							stamp_n   = stamp_q + 1'b1;
							rec.stamp = stamp_n;
							rec.ready = 1'b0;
						end
						if (cur.refs != '1) rec.refs = cur.refs + 1'b1;
						res.found = 1'b1;
					end else if (free_ok_q) begin
						we        = 1'b1;
						stamp_n   = stamp_q + 1'b1;
						rec.valid = 1'b1;
						rec.lba   = item_q.lba;
						rec.refs  = REFS_W'(1);
						rec.stamp = stamp_n;
						rec.flags = '0;
						rec.ready = 1'b0;
						held_n    = held_q + 1'b1;
						if (peak_q < held_n) peak_n = held_n;
						res.is_new = 1'b1;
					end else begin
						res.status = ST_NO_FREE;
					end
				end
				OP_RELEASE: begin
					if (!hit_q) begin
						res.status = ST_NOT_HELD;
					end else begin
						we = 1'b1;
						res.found = 1'b1;
						if (cur.refs != '0) begin
							rec.refs = cur.refs - 1'b1;
							if (rec.refs == '0) begin
								if (cur.flags[FLAG_DIRTY] && cur.flags[FLAG_UPTODATE]) begin
									if (write_back && !cur.flags[FLAG_FLUSH] &&
										!cur.flags[FLAG_TMP]) begin
										rec.ready = 1'b1;
									end else begin
										res.flush_request     = 1'b1;
										rec.flags[FLAG_FLUSH] = 1'b0;
									end
								end
								if (!rec.flags[FLAG_UPTODATE] || rec.flags[FLAG_TMP]) begin
									rec.valid = 1'b0;
									rec.ready = 1'b0;
									if (held_q != '0) held_n = held_q - 1'b1;
									res.freed = 1'b1;
								end
							end
						end
					end
				end
				OP_INVAL: res.found = any_q;
				OP_DROP: begin
					if (!hit_q) begin
						res.status = ST_NOT_HELD;
					end else begin
						we        = 1'b1;
						rec.valid = 1'b0;
						rec.ready = 1'b0;
						if (held_q != '0) held_n = held_q - 1'b1;
						res.found = 1'b1;
						res.freed = 1'b1;
					end
				end
				OP_WFLAGS: begin
					if (!hit_q) begin
						res.status = ST_NOT_HELD;
					end else begin
						we        = 1'b1;
						rec.flags = item_q.flag_bits;
						if (!item_q.flag_bits[FLAG_DIRTY]) rec.ready = 1'b0;
						res.found = 1'b1;
					end
				end
				OP_OLDEST: begin
					if (!old_ok_q) res.status = ST_NOT_HELD;
					else res.found = 1'b1;
				end
				default: ;
			endcase
			// describe the entry concerned
			if (res.found || res.is_new) begin
				res.entry_index   = act_idx;
				res.out_lba       = rec.lba;
				res.out_flags     = rec.flags;
				res.ref_count_out = rec.refs;
			end
			if (item_q.op == OP_INVAL) begin
				res.entry_index   = '0;
				res.out_lba       = '0;
				res.out_flags     = '0;
				res.ref_count_out = '0;
			end
			res.cache_full  = (held_n >= capacity);
			res.blocks_held = held_n;
			res.peak_blocks = peak_n;
			if (!out_free) we = 1'b0;
		end
	end

	// entry payload write port
	always_ff @(posedge clk) begin
		if (we) begin
			lba_q[widx]    <= rec.lba;
			refs_q[widx]   <= rec.refs;
			stampe_q[widx] <= rec.stamp;
			flags_q[widx]  <= rec.flags;
		end
	end

	// valid and ready marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				ready_q[i] <= 1'b0;
			end
		end else if (we) begin
			valid_q[widx] <= rec.valid;
			ready_q[widx] <= rec.ready;
		end
	end

	// sequencer, scan trackers, counters and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			free_ok_q   <= 1'b0;
			old_ok_q    <= 1'b0;
			any_q       <= 1'b0;
			stamp_q     <= '0;
			held_q      <= '0;
			peak_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						item_q    <= item;
						idx_q     <= '0;
						hit_q     <= 1'b0;
						free_ok_q <= 1'b0;
						old_ok_q  <= 1'b0;
						any_q     <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!cur.valid && !free_ok_q) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (cur.valid && cur.refs == '0 &&
						(!old_ok_q || cur.stamp < old_stamp_q)) begin
						old_ok_q    <= 1'b1;
						old_idx_q   <= idx_q;
						old_stamp_q <= cur.stamp;
					end
					if (item_q.op == OP_INVAL && in_range) any_q <= 1'b1;
					if (idx_q == IDX_W'(NUM_ENTRIES - 1)) state_q <= S_ACT;
					idx_q <= idx_q + 1'b1;
				end
				S_ACT: begin
					if (out_free) begin
						stamp_q     <= stamp_n;
						held_q      <= held_n;
						peak_q      <= peak_n;
						rsp_q       <= res;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.found         = rsp_q.found;
	assign rsp.is_new        = rsp_q.is_new;
	assign rsp.status        = rsp_q.status;
	assign rsp.entry_index   = rsp_q.entry_index;
	assign rsp.out_lba       = rsp_q.out_lba;
	assign rsp.out_flags     = rsp_q.out_flags;
	assign rsp.flush_request = rsp_q.flush_request;
	assign rsp.freed         = rsp_q.freed;
	assign rsp.cache_full    = rsp_q.cache_full;
	assign rsp.blocks_held   = rsp_q.blocks_held;
	assign rsp.peak_blocks   = rsp_q.peak_blocks;
	assign rsp.ref_count_out = rsp_q.ref_count_out;
endmodule

// ===== design/block_buffer_cache_lru.sv =====
// Block buffer cache tag table, LRU, 16 entries.
// Each accepted item is taken in the idle state, then a tag scan reads one entry per cycle,
// and an action step applies the operation; the engine takes no new item until it is done.
// A two-item queue in front lets requests be taken while the scan runs; a result still
// waiting on the output holds the action step. Reset (arst_n low, asynchronous) empties
// the table, counters and queues; capacity returns to 16 and write-back to off.
`timescale 1ns / 1ps
module block_buffer_cache_lru (
	input  logic                      clk,
	input  logic                      arst_n,
	bbc_req_if.sink                   req,
	bbc_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bbc_pkg::CNT_W-1:0] cfg_data
);
	import bbc_pkg::*;

	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic [CNT_W-1:0] capacity_q;
	logic             write_back_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CNT_W'(NUM_ENTRIES);
			write_back_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY:   capacity_q   <= cfg_data;
				CFG_WRITE_BACK: write_back_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	bbc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.capacity   (capacity_q),
		.write_back (write_back_q),
		.rsp        (rsp)
	);
endmodule

// ===== design/bbc_checker.sv =====
// Port-level checks of the block buffer cache, bound to the top level.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
module bbc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      found,
	input logic                      is_new,
	input logic [1:0]                status,
	input logic                      freed,
	input logic [bbc_pkg::IDX_W-1:0] entry_index,
	input logic [bbc_pkg::CNT_W-1:0] blocks_held,
	input logic [bbc_pkg::CNT_W-1:0] peak_blocks
);
	import bbc_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_index) && $stable(status))
		else $error("stalled result changed");

	// the peak never trails the current count
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> peak_blocks >= blocks_held)
		else $error("peak below held count");

	// a fresh allocation is a clean miss
	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_new |-> !found && status == ST_OK)
		else $error("allocation flagged as hit or error");

	// freeing an entry means it was found
	a_freed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && freed |-> found && status == ST_OK)
		else $error("freed without hit");

	// never more entries held than exist
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> blocks_held <= CNT_W'(NUM_ENTRIES))
		else $error("held count out of range");
endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.found       (rsp.found),
	.is_new      (rsp.is_new),
	.status      (rsp.status),
	.freed       (rsp.freed),
	.entry_index (rsp.entry_index),
	.blocks_held (rsp.blocks_held),
	.peak_blocks (rsp.peak_blocks)
);
